// File: sv/pmac_pkg.sv
// Package for the periodic multiply-accumulate unit.
// Holds the register map, the configuration and status structs and the
// control struct shared by the sequencer, the datapath and the top level.
package pmac_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int OPERAND_WIDTH   = 32;
   localparam int RESULT_WIDTH    = 32;
   localparam int PRODUCT_WIDTH   = 64;
   localparam int INDEX_WIDTH     = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ACCUMULATE_MODE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ITERATION_COUNT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PERIOD_LENGTH   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_DELAY     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESULT_SHIFT    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INDEX_STEP      = 3'd5;

   localparam logic CMD_COMPUTE = 1'b0;
   localparam logic CMD_START   = 1'b1;

   localparam logic MODE_ADD = 1'b0;
   localparam logic MODE_SUB = 1'b1;

   typedef struct packed {
      logic        accumulate_mode;
      logic [15:0] iteration_count;
      logic [15:0] period_length;
      logic [7:0]  start_delay;
      logic [5:0]  result_shift;
      logic [7:0]  index_step;
   } cfg_type;

   typedef struct packed {
      logic compute;
      logic zero_base;
      logic done;
   } ctrl_type;

   typedef struct packed {
      logic prod_ready;
      logic acc_valid;
   } pipe_status_type;

endpackage

// File: sv/periodic_mac_unit_core.sv
// Top level of the periodic multiply-accumulate unit.
// Depends on pmac_pkg, pmac_csr, pmac_seq and pmac_datapath.
// The unit takes one beat per clock cycle unless back-pressure from the result port
// stalls it, and delivers at most one result beat per cycle. A compute beat passes
// the input register, product register, accumulator register and output register
// in turn on its way to the result port. Start beats and beats spent in the
// start delay give no result. The data of a result is the shifted accumulator
// of LATENCY-1 computing beats earlier, held in the latency line, and the
// registered accumulator feedback is what sets the rate of one beat a cycle.
module periodic_mac_unit_core #(
   parameter int LATENCY    = 3,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [63:0]                         req_tdata,  // op_a[31:0], op_b[63:32]
   input  logic [0:0]                          req_tuser,  // command[0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [39:0]                         rsp_tdata,  // data_out[31:0], done_res[32], zero
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pmac_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);

   pmac_pkg::cfg_type                         cfg;
   pmac_pkg::ctrl_type                        ctrl;
   pmac_pkg::pipe_status_type                 status;
   logic                                      in_vld_ff;
   logic                                      in_cmd_ff;
   logic signed [pmac_pkg::OPERAND_WIDTH-1:0] in_op_a_ff;
   logic signed [pmac_pkg::OPERAND_WIDTH-1:0] in_op_b_ff;
   logic                                      in_move;
   logic                                      req_take;
   logic signed [pmac_pkg::RESULT_WIDTH-1:0]  data_out;
   logic                                      done_res;

   assign in_move    = in_vld_ff && status.prod_ready;
   assign req_tready = !in_vld_ff || status.prod_ready;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_tuser[0];
         in_op_a_ff <= req_tdata[31:0];
         in_op_b_ff <= req_tdata[63:32];
      end
   end

   pmac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pmac_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step    (in_move),
      .command (in_cmd_ff),
      .ctrl    (ctrl)
   );

   pmac_datapath #(
      .LATENCY    (LATENCY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_move && ctrl.compute),
      .ctrl      (ctrl),
      .op_a      (in_op_a_ff),
      .op_b      (in_op_b_ff),
      .status    (status),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .data_out  (data_out),
      .done_res  (done_res)
   );

   assign rsp_tdata = {7'd0, done_res, data_out};

   // A stalled beat in the input register keeps its command.
   assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !status.prod_ready) |=> (in_vld_ff && $stable(in_cmd_ff)))
      else $error("input register lost a stalled beat");

   // A result appears only when the accumulator stage held a beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(status.acc_valid))
      else $error("result raised without an accumulated beat");

   // A start beat never reaches the multiplier as a compute beat.
   assert property (@(posedge clock) disable iff (reset)
      (in_move && (in_cmd_ff == pmac_pkg::CMD_START)) |-> !ctrl.compute)
      else $error("start beat treated as compute beat");

endmodule

// File: sv/pmac_csr.sv
// Configuration register file of the periodic multiply-accumulate unit.
// Depends on pmac_pkg for the register map and the configuration struct.
module pmac_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [pmac_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output pmac_pkg::cfg_type                   cfg
);

   pmac_pkg::cfg_type cfg_ff;
   pmac_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pmac_pkg::REG_ACCUMULATE_MODE: cfg_in.accumulate_mode = csr_data[0];
            pmac_pkg::REG_ITERATION_COUNT: cfg_in.iteration_count = csr_data[15:0];
            pmac_pkg::REG_PERIOD_LENGTH:   cfg_in.period_length   = csr_data[15:0];
            pmac_pkg::REG_START_DELAY:     cfg_in.start_delay     = csr_data[7:0];
            pmac_pkg::REG_RESULT_SHIFT:    cfg_in.result_shift    = csr_data[5:0];
            pmac_pkg::REG_INDEX_STEP:      cfg_in.index_step      = csr_data[7:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accumulate_mode <= pmac_pkg::MODE_ADD;
         cfg_ff.iteration_count <= 16'd1;
         cfg_ff.period_length   <= 16'd1;
         cfg_ff.start_delay     <= 8'd0;
         cfg_ff.result_shift    <= 6'd0;
         cfg_ff.index_step      <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/pmac_seq.sv
// Run sequencer: start delay counter, periodic index generator and done flag.
// Depends on pmac_pkg; steps once per beat leaving the input register.
module pmac_seq (
   input  logic              clock,
   input  logic              reset,
   input  pmac_pkg::cfg_type cfg,
   input  logic              step,
   input  logic              command,
   output pmac_pkg::ctrl_type ctrl
);

   logic [7:0]                       delay_left_ff, delay_left_in;
   logic [15:0]                      period_pos_ff, period_pos_in;
   logic [15:0]                      iter_pos_ff, iter_pos_in;
   logic [pmac_pkg::INDEX_WIDTH-1:0] index_pos_ff, index_pos_in;
   logic [pmac_pkg::INDEX_WIDTH-1:0] held_index_ff, held_index_in;
   logic                             done_ff, done_in;
   logic                             compute;

   assign compute = (command == pmac_pkg::CMD_COMPUTE) && (delay_left_ff == 8'd0);

   always_comb begin
      delay_left_in = delay_left_ff;
      period_pos_in = period_pos_ff;
      iter_pos_in   = iter_pos_ff;
      index_pos_in  = index_pos_ff;
      held_index_in = held_index_ff;
      done_in       = done_ff;
      if (command == pmac_pkg::CMD_START) begin
         delay_left_in = cfg.start_delay;
         period_pos_in = 16'd0;
         iter_pos_in   = 16'd0;
         index_pos_in  = '0;
         held_index_in = '0;
         done_in       = 1'b0;
      end else if (delay_left_ff != 8'd0) begin
         delay_left_in = delay_left_ff - 8'd1;
      end else begin
         if (iter_pos_ff < cfg.iteration_count) begin
            if (period_pos_ff < cfg.period_length) begin
               period_pos_in = period_pos_ff + 16'd1;
               held_index_in = index_pos_ff;
               index_pos_in  = index_pos_ff + pmac_pkg::INDEX_WIDTH'(cfg.index_step);
            end
            if (period_pos_in == cfg.period_length) begin
               period_pos_in = 16'd0;
               iter_pos_in   = iter_pos_ff + 16'd1;
               index_pos_in  = index_pos_in - pmac_pkg::INDEX_WIDTH'(cfg.period_length);
            end
         end
         if (iter_pos_in == cfg.iteration_count) begin
            iter_pos_in = 16'd0;
            done_in     = 1'b1;
         end
      end
   end

   assign ctrl.compute   = compute;
   assign ctrl.zero_base = (held_index_in == '0);
   assign ctrl.done      = done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_left_ff <= 8'd0;
         period_pos_ff <= 16'd0;
         iter_pos_ff   <= 16'd0;
         index_pos_ff  <= '0;
         held_index_ff <= '0;
         done_ff       <= 1'b0;
      end else if (step) begin
         delay_left_ff <= delay_left_in;
         period_pos_ff <= period_pos_in;
         iter_pos_ff   <= iter_pos_in;
         index_pos_ff  <= index_pos_in;
         held_index_ff <= held_index_in;
         done_ff       <= done_in;
      end
   end

endmodule

// File: sv/pmac_datapath.sv
// Datapath: product register, accumulator, output shifter and latency line.
// Depends on pmac_pkg; each stage moves on when the stage after it is free.
module pmac_datapath #(
   parameter int LATENCY    = 3,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  pmac_pkg::cfg_type                         cfg,
   input  logic                                      in_valid,
   input  pmac_pkg::ctrl_type                        ctrl,
   input  logic signed [pmac_pkg::OPERAND_WIDTH-1:0] op_a,
   input  logic signed [pmac_pkg::OPERAND_WIDTH-1:0] op_b,
   output pmac_pkg::pipe_status_type                 status,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic signed [pmac_pkg::RESULT_WIDTH-1:0]  data_out,
   output logic                                      done_res
);

   logic                                      prod_vld_ff;
   logic signed [pmac_pkg::PRODUCT_WIDTH-1:0] prod_ff;
   logic                                      prod_zero_ff;
   logic                                      prod_done_ff;
   logic                                      acc_vld_ff;
   logic [pmac_pkg::PRODUCT_WIDTH-1:0]        acc_ff, acc_in;
   logic                                      acc_done_ff;
   logic                                      out_vld_ff;
   logic                                      out_done_ff;
   logic [DATA_WIDTH-1:0]                     line_ff [LATENCY];
   logic [pmac_pkg::PRODUCT_WIDTH-1:0]        shifted;
   logic                                      out_free, acc_free, prod_free;
   logic                                      acc_move, prod_move;
   logic [pmac_pkg::PRODUCT_WIDTH-1:0]        base;

   assign out_free  = !out_vld_ff || out_ready;
   assign acc_free  = !acc_vld_ff || out_free;
   assign prod_free = !prod_vld_ff || acc_free;
   assign acc_move  = acc_vld_ff && out_free;
   assign prod_move = prod_vld_ff && acc_free;

   assign status.prod_ready = prod_free;
   assign status.acc_valid  = acc_vld_ff;

   assign base   = prod_zero_ff ? '0 : acc_ff;
   assign acc_in = (cfg.accumulate_mode == pmac_pkg::MODE_SUB) ?
                   base - pmac_pkg::PRODUCT_WIDTH'(prod_ff) :
                   base + pmac_pkg::PRODUCT_WIDTH'(prod_ff);

   assign shifted = pmac_pkg::PRODUCT_WIDTH'($signed(acc_ff) >>> cfg.result_shift);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
         acc_ff      <= '0;
         for (int i = 0; i < LATENCY; i++) begin
            line_ff[i] <= '0;
         end
      end else begin
         if (prod_free) begin
            prod_vld_ff <= in_valid;
         end
         if (acc_free) begin
            acc_vld_ff <= prod_vld_ff;
         end
         if (out_free) begin
            out_vld_ff <= acc_vld_ff;
         end
         if (prod_move) begin
            acc_ff <= acc_in;
         end
         if (acc_move) begin
            line_ff[0] <= shifted[DATA_WIDTH-1:0];
            for (int i = 1; i < LATENCY; i++) begin
               line_ff[i] <= line_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && prod_free) begin
         prod_ff      <= op_a * op_b;
         prod_zero_ff <= ctrl.zero_base;
         prod_done_ff <= ctrl.done;
      end
      if (prod_move) begin
         acc_done_ff <= prod_done_ff;
      end
      if (acc_move) begin
         out_done_ff <= acc_done_ff;
      end
   end

   assign out_valid = out_vld_ff;
   assign data_out  = pmac_pkg::RESULT_WIDTH'($signed(line_ff[LATENCY-1]));
   assign done_res  = out_done_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for periodic_mac_unit_core, using types and codes from pmac_pkg.
// A directed table and then random runs are compared against a built-in multiply-accumulate
// predictor, under several levels of handshake pressure on both streams.
module testbench;

   localparam int MAC_LATENCY     = 3;
   localparam int MAC_DATA_WIDTH  = 32;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int ITEMS_PER_PHASE = 430;
   localparam int DIRECTED_ROWS   = 35;

   localparam logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_HI = 3'd7;

   localparam logic [31:0] OP_MIN  = 32'h8000_0000;
   localparam logic [31:0] OP_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] OP_ONES = 32'hffff_ffff;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                         kind;
      logic                                 cmd;
      logic [31:0]                          op_a;
      logic [31:0]                          op_b;
      logic                                 typed;
      logic [31:0]                          exp_data;
      logic                                 exp_done;
      logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] reg_index;
      logic [pmac_pkg::CSR_DATA_WIDTH-1:0]  reg_value;
   } stim_row_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic        done_res;
   } mac_sum_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [63:0]                          req_tdata;  // op_a[31:0], op_b[63:32]
   logic [0:0]                           req_tuser;  // command[0]
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [39:0]                          rsp_tdata;  // data_out[31:0], done_res[32], zero
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [pmac_pkg::CSR_DATA_WIDTH-1:0]  csr_data;

   pmac_pkg::cfg_type mac_cfg;
   logic [7:0]        delay_left;
   logic [15:0]       period_pos;
   logic [15:0]       iter_pos;
   logic [31:0]       index_pos;
   logic [31:0]       held_index;
   logic              done_flag;
   logic [63:0]       acc;
   logic [31:0]       mac_line [MAC_LATENCY];

   mac_sum_type  sum_queue [$];
   mac_sum_type  want;
   stim_row_type directed_rows [DIRECTED_ROWS];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int beats_sent     = 0;
   int starts_sent    = 0;
   int regs_written   = 0;
   int sums_checked   = 0;
   int errors         = 0;
   int idle_cycles    = 0;

   periodic_mac_unit_core #(
      .LATENCY    (MAC_LATENCY),
      .DATA_WIDTH (MAC_DATA_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic stim_row_type beat_row(input logic cmd, input logic [31:0] a, b);
      stim_row_type row;
      row = '0;
      row.kind = ROW_BEAT;
      row.cmd = cmd;
      row.op_a = a;
      row.op_b = b;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [31:0] a, b, data,
                                                input logic done);
      stim_row_type row;
      row = beat_row(pmac_pkg::CMD_COMPUTE, a, b);
      row.typed = 1'b1;
      row.exp_data = data;
      row.exp_done = done;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] index,
                                            input logic [pmac_pkg::CSR_DATA_WIDTH-1:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.cmd = pmac_pkg::CMD_COMPUTE;
      row.reg_index = index;
      row.reg_value = value;
      return row;
   endfunction

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(9))
         0: return OP_MIN;
         1: return OP_MAX;
         2: return OP_ONES;
         3: return 32'd0;
         4, 5: return 32'($urandom_range(0, 200)) - 32'd100;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] with_junk(input int width, input logic [15:0] value);
      logic [15:0] field_mask;
      field_mask = 16'((32'd1 << width) - 1);
      if ($urandom_range(1) == 0) return value;
      return value | (16'($urandom) & ~field_mask);
   endfunction

   // Advances the multiply-accumulate state by one beat; returns its sum if it has one.
   task automatic mac_step(input logic cmd, input logic [31:0] a, b,
                           output logic has_sum, output mac_sum_type sum);
      logic signed [63:0] wide_a;
      logic signed [63:0] wide_b;
      logic signed [63:0] product;
      logic signed [63:0] shifted;
      logic [63:0]        base;
      has_sum = 1'b0;
      sum = '0;
      if (cmd == pmac_pkg::CMD_START) begin
         delay_left = mac_cfg.start_delay;
         period_pos = '0;
         iter_pos = '0;
         index_pos = '0;
         held_index = '0;
         done_flag = 1'b0;
         return;
      end
      if (delay_left != 0) begin
         delay_left--;
         return;
      end
      if (iter_pos < mac_cfg.iteration_count) begin
         if (period_pos < mac_cfg.period_length) begin
            period_pos++;
            held_index = index_pos;
            index_pos += mac_cfg.index_step;
         end
         if (period_pos == mac_cfg.period_length) begin
            period_pos = '0;
            iter_pos++;
            index_pos -= mac_cfg.period_length;
         end
      end
      if (iter_pos == mac_cfg.iteration_count) begin
         iter_pos = '0;
         done_flag = 1'b1;
      end
      wide_a = $signed(a);
      wide_b = $signed(b);
      product = wide_a * wide_b;
      base = (held_index == 0) ? 64'd0 : acc;
      acc = (mac_cfg.accumulate_mode == pmac_pkg::MODE_SUB) ? base - product : base + product;
      shifted = $signed(acc) >>> mac_cfg.result_shift;
      for (int i = MAC_LATENCY - 1; i > 0; i--) mac_line[i] = mac_line[i-1];
      mac_line[0] = 32'($signed(shifted[MAC_DATA_WIDTH-1:0]));
      sum.data_out = mac_line[MAC_LATENCY-1];
      sum.done_res = done_flag;
      has_sum = 1'b1;
   endtask

   task automatic send_beat(input logic cmd, input logic [31:0] a, b,
                            input logic typed, input mac_sum_type typed_sum);
      logic        has_sum;
      mac_sum_type sum;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
      if (cmd == pmac_pkg::CMD_START) starts_sent++;
      mac_step(cmd, a, b, has_sum, sum);
      if (has_sum) sum_queue.push_back(typed ? typed_sum : sum);
   endtask

   task automatic write_reg(input logic [pmac_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [pmac_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      regs_written++;
      case (index)
         pmac_pkg::REG_ACCUMULATE_MODE: mac_cfg.accumulate_mode = value[0];
         pmac_pkg::REG_ITERATION_COUNT: mac_cfg.iteration_count = value;
         pmac_pkg::REG_PERIOD_LENGTH:   mac_cfg.period_length = value;
         pmac_pkg::REG_START_DELAY:     mac_cfg.start_delay = value[7:0];
         pmac_pkg::REG_RESULT_SHIFT:    mac_cfg.result_shift = value[5:0];
         pmac_pkg::REG_INDEX_STEP:      mac_cfg.index_step = value[7:0];
         default: ;
      endcase
   endtask

   // Waits until every expected sum has arrived and beats that give none have left the pipe.
   task automatic settle_unit();
      csr_valid <= 1'b0;
      req_tvalid <= 1'b0;
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_pass();
      logic [15:0] iters;
      logic [15:0] period;
      logic [7:0]  delay;
      logic [5:0]  shift;
      logic [7:0]  step;
      int          count;
      int          lower_at;
      case ($urandom_range(9))
         0: iters = 16'd0;
         1: iters = 16'hffff;
         default: iters = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(9))
         0: period = 16'd0;
         1: period = 16'hffff;
         default: period = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(39))
         0: delay = 8'hff;
         1, 2, 3, 4: delay = 8'($urandom_range(1, 4));
         default: delay = 8'd0;
      endcase
      case ($urandom_range(5))
         0: shift = 6'd0;
         1: shift = 6'd63;
         default: shift = 6'($urandom_range(63));
      endcase
      case ($urandom_range(7))
         0: step = 8'd0;
         1: step = 8'hff;
         2: step = 8'($urandom_range(255));
         default: step = 8'd1;
      endcase
      settle_unit();
      write_reg(pmac_pkg::REG_ACCUMULATE_MODE, with_junk(1, 16'($urandom_range(1))));
      write_reg(pmac_pkg::REG_ITERATION_COUNT, iters);
      write_reg(pmac_pkg::REG_PERIOD_LENGTH, period);
      write_reg(pmac_pkg::REG_START_DELAY, with_junk(8, 16'(delay)));
      write_reg(pmac_pkg::REG_RESULT_SHIFT, with_junk(6, 16'(shift)));
      write_reg(pmac_pkg::REG_INDEX_STEP, with_junk(8, 16'(step)));
      if ($urandom_range(7) == 0)
         write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, 16'($urandom));
      if ($urandom_range(9) != 0)
         send_beat(pmac_pkg::CMD_START, pick_operand(), pick_operand(), 1'b0, '0);
      count = $urandom_range(4, 40) + delay;
      lower_at = ($urandom_range(9) == 0) ? $urandom_range(1, count - 1) : -1;
      for (int i = 0; i < count; i++) begin
         if (i == lower_at) begin
            settle_unit();
            write_reg(pmac_pkg::REG_PERIOD_LENGTH, 16'($urandom_range(0, 2)));
         end
         send_beat(($urandom_range(24) == 0) ? pmac_pkg::CMD_START : pmac_pkg::CMD_COMPUTE,
                   pick_operand(), pick_operand(), 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sum_queue.size() == 0) begin
            $error("result beat with no sum expected: data_out %h", rsp_tdata[31:0]);
            errors++;
         end else begin
            want = sum_queue.pop_front();
            sums_checked++;
            if (rsp_tdata[31:0] !== want.data_out) begin
               $error("data_out: expected %h, got %h", want.data_out, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[32] !== want.done_res) begin
               $error("done_res: expected %b, got %b", want.done_res, rsp_tdata[32]);
               errors++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int           phase_start;
      stim_row_type row;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= pmac_pkg::CMD_COMPUTE;
      csr_valid <= 1'b0;
      csr_index <= pmac_pkg::REG_ACCUMULATE_MODE;
      csr_data <= '0;
      mac_cfg.accumulate_mode = pmac_pkg::MODE_ADD;
      mac_cfg.iteration_count = 16'd1;
      mac_cfg.period_length = 16'd1;
      mac_cfg.start_delay = 8'd0;
      mac_cfg.result_shift = 6'd0;
      mac_cfg.index_step = 8'd1;
      delay_left = '0;
      period_pos = '0;
      iter_pos = '0;
      index_pos = '0;
      held_index = '0;
      done_flag = 1'b0;
      acc = '0;
      foreach (mac_line[i]) mac_line[i] = '0;

      // With the reset settings every beat closes a one-beat run, so each sum is the bare
      // product and the output is the low word of the product two beats back.
      directed_rows = '{
         beat_row(pmac_pkg::CMD_START, OP_ONES, OP_ONES),
         checked_row(OP_MAX, OP_MAX, 32'h0000_0000, 1'b1),
         checked_row(OP_MIN, OP_MIN, 32'h0000_0000, 1'b1),
         checked_row(OP_MIN, OP_MAX, 32'h0000_0001, 1'b1),
         checked_row(OP_ONES, OP_ONES, 32'h0000_0000, 1'b1),
         checked_row(OP_ONES, 32'd1, 32'h8000_0000, 1'b1),
         checked_row(32'd0, 32'd0, 32'h0000_0001, 1'b1),
         checked_row(32'd5, -32'sd7, 32'hffff_ffff, 1'b1),
         beat_row(pmac_pkg::CMD_START, OP_MAX, OP_MAX),
         checked_row(32'd3, 32'd4, 32'h0000_0000, 1'b1),
         csr_row(pmac_pkg::REG_ACCUMULATE_MODE, 16'(pmac_pkg::MODE_SUB)),
         csr_row(pmac_pkg::REG_RESULT_SHIFT, 16'd63),
         csr_row(pmac_pkg::REG_ITERATION_COUNT, 16'd0),
         beat_row(pmac_pkg::CMD_COMPUTE, 32'h0012_d687, 32'hffff_ffa7),
         beat_row(pmac_pkg::CMD_COMPUTE, OP_MIN, OP_MAX),
         csr_row(pmac_pkg::REG_ITERATION_COUNT, 16'd3),
         csr_row(pmac_pkg::REG_PERIOD_LENGTH, 16'd0),
         csr_row(pmac_pkg::REG_INDEX_STEP, 16'd255),
         csr_row(pmac_pkg::REG_START_DELAY, 16'd2),
         beat_row(pmac_pkg::CMD_START, 32'd0, 32'd0),
         beat_row(pmac_pkg::CMD_COMPUTE, 32'd7, 32'd9),
         beat_row(pmac_pkg::CMD_COMPUTE, 32'd11, 32'd13),
         beat_row(pmac_pkg::CMD_COMPUTE, 32'h4000_0000, 32'h4000_0000),
         csr_row(pmac_pkg::REG_PERIOD_LENGTH, 16'd4),
         csr_row(pmac_pkg::REG_START_DELAY, 16'd0),
         csr_row(pmac_pkg::REG_RESULT_SHIFT, 16'd1),
         csr_row(pmac_pkg::REG_ACCUMULATE_MODE, 16'(pmac_pkg::MODE_ADD)),
         beat_row(pmac_pkg::CMD_START, 32'd1, 32'd1),
         beat_row(pmac_pkg::CMD_COMPUTE, 32'd100, -32'sd3),
         beat_row(pmac_pkg::CMD_COMPUTE, -32'sd50, 32'd2),
         csr_row(pmac_pkg::REG_PERIOD_LENGTH, 16'd1),
         csr_row(REG_UNUSED_LO, 16'hffff),
         csr_row(REG_UNUSED_HI, 16'h1234),
         beat_row(pmac_pkg::CMD_COMPUTE, 32'd17, 32'd19),
         beat_row(pmac_pkg::CMD_COMPUTE, OP_MAX, 32'd2)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            settle_unit();
            write_reg(row.reg_index, row.reg_value);
         end else begin
            send_beat(row.cmd, row.op_a, row.op_b, row.typed, {row.exp_data, row.exp_done});
         end
      end

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase
         phase_start = beats_sent;
         while (beats_sent - phase_start < ITEMS_PER_PHASE) run_pass();
      end

      settle_unit();
      $display("Ran %0d input beats with %0d starts and %0d register writes;",
               beats_sent, starts_sent, regs_written);
      $display("%0d result beats checked, under pressure from none to heavy idling and stalling.",
               sums_checked);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/pmac_pkg.sv
sv/pmac_csr.sv
sv/pmac_seq.sv
sv/pmac_datapath.sv
sv/periodic_mac_unit_core.sv
tb/sv/testbench.sv
